[rtl/core/llcp_pkg.sv]
// Shared constants and types for the line-line closest points unit.
// Used by the top level, the divider and the square root pipelines.
package llcp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned QuoBits     = 33;
  localparam int unsigned DivLat      = QuoBits + 3;
  localparam int unsigned RootBits    = 32;

  localparam logic [DataW-1:0]   LimitReset = 32'd4295;
  localparam logic [DataW-1:0]   SatPos     = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]   SatNeg     = 32'h8000_0000;
  localparam logic [QuoBits-1:0] LimPos     = 33'h0_7FFF_FFFF;
  localparam logic [QuoBits-1:0] LimNeg     = 33'h0_8000_0000;

  typedef enum logic [0:0] {
    REG_PARALLEL_LIMIT = 1'b0
  } reg_idx_e;

endpackage

[rtl/core/llcp_smul.sv]
// Two-stage signed multiplier built from partial products split at bit 32 of each operand.
// Standalone; operands must be wider than 32 bits.
module llcp_smul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 48
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned LoW = 32;
  localparam int unsigned AHW = AW - LoW;
  localparam int unsigned BHW = BW - LoW;
  localparam int unsigned LLW = 2 * LoW + 2;
  localparam int unsigned LHW = LoW + 1 + BHW;
  localparam int unsigned HLW = AHW + LoW + 1;
  localparam int unsigned HHW = AHW + BHW;
  localparam int unsigned PW  = AW + BW;

  logic signed [LoW:0]   a_lo, b_lo;
  logic signed [AHW-1:0] a_hi;
  logic signed [BHW-1:0] b_hi;
  logic signed [LLW-1:0] ll_q;
  logic signed [LHW-1:0] lh_q;
  logic signed [HLW-1:0] hl_q;
  logic signed [HHW-1:0] hh_q;
  logic signed [PW-1:0]  p_q;

  assign a_lo = $signed({1'b0, a_i[LoW-1:0]});
  assign b_lo = $signed({1'b0, b_i[LoW-1:0]});
  assign a_hi = $signed(a_i[AW-1:LoW]);
  assign b_hi = $signed(b_i[BW-1:LoW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= LLW'(a_lo) * LLW'(b_lo);
      lh_q <= LHW'(a_lo) * LHW'(b_hi);
      hl_q <= HLW'(a_hi) * HLW'(b_lo);
      hh_q <= HHW'(a_hi) * HHW'(b_hi);
      p_q  <= (PW'(hh_q) <<< (2 * LoW)) + (PW'(lh_q) <<< LoW) + (PW'(hl_q) <<< LoW)
              + PW'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

[rtl/core/llcp_div.sv]
// Pipelined restoring divider giving a saturated signed fixed-point quotient.
// One quotient bit per stage; depends on llcp_pkg.
module llcp_div
  import llcp_pkg::*;
#(
  parameter int unsigned NW        = 103,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NW-1:0]    num_i,
  input  logic signed [NW-1:0]    den_i,
  output logic signed [DataW-1:0] quo_o,
  output logic                    deg_o
);

  localparam int unsigned RW = NW + QuoBits;

  typedef struct packed {
    logic neg;
    logic num_neg;
    logic ovf;
    logic dzero;
    logic nzero;
  } div_flags_t;

  logic [NW-1:0]      nm_c, dm_c;
  logic [NW-1:0]      nm_a_q, dm_a_q;
  logic               neg_a_q, nneg_a_q;
  logic [RW-1:0]      rem_q  [QuoBits+1];
  logic [NW-1:0]      dv_q   [QuoBits+1];
  logic [QuoBits-1:0] q_q    [QuoBits+1];
  div_flags_t         fl_q   [QuoBits+1];
  div_flags_t         fl_last;
  logic [QuoBits-1:0] lim, mag;
  logic               sat;
  logic signed [DataW-1:0] quo_d, quo_q;
  logic               deg_q;

  assign nm_c = num_i[NW-1] ? $unsigned(-num_i) : $unsigned(num_i);
  assign dm_c = den_i[NW-1] ? $unsigned(-den_i) : $unsigned(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_a_q   <= nm_c;
      dm_a_q   <= dm_c;
      neg_a_q  <= num_i[NW-1] ^ den_i[NW-1];
      nneg_a_q <= num_i[NW-1];
      rem_q[0] <= RW'(nm_a_q) << FRAC_BITS;
      dv_q[0]  <= dm_a_q;
      q_q[0]   <= '0;
      fl_q[0]  <= '{neg:     neg_a_q,
                    num_neg: nneg_a_q,
                    ovf:     (RW'(nm_a_q) << FRAC_BITS) >= (RW'(dm_a_q) << QuoBits),
                    dzero:   dm_a_q == '0,
                    nzero:   nm_a_q == '0};
    end
  end

  for (genvar j = 0; j < QuoBits; j++) begin : g_step
    localparam int unsigned Sh = QuoBits - 1 - j;
    logic [RW-1:0] trial;
    assign trial = RW'(dv_q[j]) << Sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[j] >= trial) begin
          rem_q[j+1] <= rem_q[j] - trial;
          q_q[j+1]   <= q_q[j] | (QuoBits'(1) << Sh);
        end else begin
          rem_q[j+1] <= rem_q[j];
          q_q[j+1]   <= q_q[j];
        end
        dv_q[j+1] <= dv_q[j];
        fl_q[j+1] <= fl_q[j];
      end
    end
  end

  assign fl_last = fl_q[QuoBits];

  always_comb begin
    lim   = fl_last.neg ? LimNeg : LimPos;
    sat   = fl_last.ovf || (q_q[QuoBits] > lim);
    mag   = sat ? lim : q_q[QuoBits];
    quo_d = fl_last.neg ? $signed(DataW'(QuoBits'(0) - mag)) : $signed(DataW'(mag));
    if (fl_last.dzero) begin
      if (fl_last.nzero) begin
        quo_d = '0;
      end else begin
        quo_d = fl_last.num_neg ? $signed(SatNeg) : $signed(SatPos);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      deg_q <= fl_last.dzero || sat;
    end
  end

  assign quo_o = quo_q;
  assign deg_o = deg_q;

endmodule

[rtl/core/llcp_sqrt.sv]
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on llcp_pkg for the root width.
module llcp_sqrt
  import llcp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*RootBits-1:0] val_i,
  output logic [RootBits-1:0]   root_o
);

  localparam int unsigned RemW = 2 * RootBits + 2;

  logic [RemW-1:0]     rem_q [RootBits];
  logic [RootBits-1:0] res_q [RootBits];

  for (genvar j = 0; j < RootBits; j++) begin : g_step
    localparam int unsigned Bit = RootBits - 1 - j;
    logic [RemW-1:0]     rem_in, trial;
    logic [RootBits-1:0] res_in;
    if (j == 0) begin : g_first
      assign rem_in = RemW'(val_i);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end
    assign trial = (RemW'(res_in) << (Bit + 1)) + (RemW'(1) << (2 * Bit));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          res_q[j] <= res_in | (RootBits'(1) << Bit);
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in;
        end
      end
    end
  end

  assign root_o = res_q[RootBits-1];

endmodule

[rtl/core/llcp_dly.sv]
// Enabled shift register that carries side data and valid bits down the pipeline.
// Standalone.
module llcp_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) sr_q[k] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < N; k++) sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

[rtl/core/line_line_closest_points_unit.sv]
// Closest points between two 3D lines given in signed fixed point. The unit takes one
// transaction per clock while in_stall_o is low; most of the pipeline depth lies in the
// 33-stage quotient pipeline and the 32-stage square root pipeline. Results leave in
// acceptance order through an output register, and the pipeline keeps running while that
// register waits, so bubbles are squeezed out before the input is stalled. Depends on
// llcp_pkg, llcp_smul, llcp_div, llcp_sqrt and llcp_dly.
module line_line_closest_points_unit
  import llcp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] first_origin_x_i,
  input  logic signed [DataW-1:0] first_origin_y_i,
  input  logic signed [DataW-1:0] first_origin_z_i,
  input  logic signed [DataW-1:0] first_dir_x_i,
  input  logic signed [DataW-1:0] first_dir_y_i,
  input  logic signed [DataW-1:0] first_dir_z_i,
  input  logic signed [DataW-1:0] second_origin_x_i,
  input  logic signed [DataW-1:0] second_origin_y_i,
  input  logic signed [DataW-1:0] second_origin_z_i,
  input  logic signed [DataW-1:0] second_dir_x_i,
  input  logic signed [DataW-1:0] second_dir_y_i,
  input  logic signed [DataW-1:0] second_dir_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DataW-1:0]        closest_distance_o,
  output logic signed [DataW-1:0] first_param_o,
  output logic signed [DataW-1:0] second_param_o,
  output logic                    parallel_flag_o,
  output logic                    degenerate_flag_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  localparam int unsigned GW    = DataW + 1;
  localparam int unsigned PW    = DataW + GW;
  localparam int unsigned SW3   = PW + 2;
  localparam int unsigned DW    = SW3 - FRAC_BITS;
  localparam int unsigned MW    = 2 * DW;
  localparam int unsigned NW    = MW + 1;
  localparam int unsigned CW    = 2 * DataW + 2;
  localparam int unsigned QW    = CW - FRAC_BITS;
  localparam int unsigned SQW   = 2 * QW;
  localparam int unsigned SSW   = SQW + 2;
  localparam int unsigned RadW  = 2 * RootBits;
  localparam int unsigned SideW = 6 * DataW + 3 * GW;
  localparam int unsigned LatS1   = 1;
  localparam int unsigned LatDots = 3;
  localparam int unsigned LatDet  = 6;
  localparam int unsigned LatSel  = 7;
  localparam int unsigned LatDiv  = LatSel + DivLat;
  localparam int unsigned LatSum  = LatDiv + 5;
  localparam int unsigned LatEnd  = LatSum + RootBits;

  logic en;
  logic v_end;
  logic [DataW-1:0] limit_q;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PARALLEL_LIMIT)) begin
      limit_q <= pwdata;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PARALLEL_LIMIT: prdata = limit_q;
      default:            prdata = '0;
    endcase
  end

  // Stage 1: register directions and origin gap.
  logic signed [DataW-1:0] org1 [3], org2 [3], in_d1 [3], in_d2 [3];
  logic signed [DataW-1:0] dir1_q [3], dir2_q [3];
  logic signed [GW-1:0]    gap_q [3];

  assign org1[0]  = first_origin_x_i;
  assign org1[1]  = first_origin_y_i;
  assign org1[2]  = first_origin_z_i;
  assign org2[0]  = second_origin_x_i;
  assign org2[1]  = second_origin_y_i;
  assign org2[2]  = second_origin_z_i;
  assign in_d1[0] = first_dir_x_i;
  assign in_d1[1] = first_dir_y_i;
  assign in_d1[2] = first_dir_z_i;
  assign in_d2[0] = second_dir_x_i;
  assign in_d2[1] = second_dir_y_i;
  assign in_d2[2] = second_dir_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dir1_q[k] <= in_d1[k];
        dir2_q[k] <= in_d2[k];
        gap_q[k]  <= GW'(org1[k]) - GW'(org2[k]);
      end
    end
  end

  // Stage 2: component products.
  logic signed [PW-1:0] pr_uu_q [3], pr_uv_q [3], pr_vv_q [3], pr_uw_q [3], pr_vw_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_uu_q[k] <= PW'(dir1_q[k]) * PW'(dir1_q[k]);
        pr_uv_q[k] <= PW'(dir1_q[k]) * PW'(dir2_q[k]);
        pr_vv_q[k] <= PW'(dir2_q[k]) * PW'(dir2_q[k]);
        pr_uw_q[k] <= PW'(dir1_q[k]) * PW'(gap_q[k]);
        pr_vw_q[k] <= PW'(dir2_q[k]) * PW'(gap_q[k]);
      end
    end
  end

  // Stage 3: dot products, floored to the working format.
  function automatic logic signed [DW-1:0] dot3(input logic signed [PW-1:0] p [3]);
    logic signed [SW3-1:0] acc;
    acc = SW3'(p[0]) + SW3'(p[1]) + SW3'(p[2]);
    return DW'(acc >>> FRAC_BITS);
  endfunction

  logic signed [DW-1:0] duu_q, duv_q, dvv_q, duw_q, dvw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      duu_q <= dot3(pr_uu_q);
      duv_q <= dot3(pr_uv_q);
      dvv_q <= dot3(pr_vv_q);
      duw_q <= dot3(pr_uw_q);
      dvw_q <= dot3(pr_vw_q);
    end
  end

  // Stages 4 and 5: wide products for the determinant and numerators.
  logic signed [MW-1:0] p_uudvv, p_uvuv, p_uvvw, p_vvuw, p_uuvw, p_uvuw;

  llcp_smul #(.AW(DW), .BW(DW)) u_mul_uudvv (
    .clk_i, .en_i(en), .a_i(duu_q), .b_i(dvv_q), .p_o(p_uudvv));
  llcp_smul #(.AW(DW), .BW(DW)) u_mul_uvuv (
    .clk_i, .en_i(en), .a_i(duv_q), .b_i(duv_q), .p_o(p_uvuv));
  llcp_smul #(.AW(DW), .BW(DW)) u_mul_uvvw (
    .clk_i, .en_i(en), .a_i(duv_q), .b_i(dvw_q), .p_o(p_uvvw));
  llcp_smul #(.AW(DW), .BW(DW)) u_mul_vvuw (
    .clk_i, .en_i(en), .a_i(dvv_q), .b_i(duw_q), .p_o(p_vvuw));
  llcp_smul #(.AW(DW), .BW(DW)) u_mul_uuvw (
    .clk_i, .en_i(en), .a_i(duu_q), .b_i(dvw_q), .p_o(p_uuvw));
  llcp_smul #(.AW(DW), .BW(DW)) u_mul_uvuw (
    .clk_i, .en_i(en), .a_i(duv_q), .b_i(duw_q), .p_o(p_uvuw));

  logic [4*DW-1:0]      dots_dly;
  logic signed [DW-1:0] duv6, dvv6, duw6, dvw6;

  llcp_dly #(.W(4 * DW), .N(LatDet - LatDots)) u_dly_dots (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({duv_q, dvv_q, duw_q, dvw_q}), .q_o(dots_dly));

  assign duv6 = $signed(dots_dly[4*DW-1:3*DW]);
  assign dvv6 = $signed(dots_dly[3*DW-1:2*DW]);
  assign duw6 = $signed(dots_dly[2*DW-1:DW]);
  assign dvw6 = $signed(dots_dly[DW-1:0]);

  // Stage 6: determinant and numerators.
  logic signed [NW-1:0] det_q, ns_q, nt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= NW'(p_uudvv) - NW'(p_uvuv);
      ns_q  <= NW'(p_uvvw) - NW'(p_vvuw);
      nt_q  <= NW'(p_uuvw) - NW'(p_uvuw);
    end
  end

  // Stage 7: parallel test and divider operand selection.
  logic                 par_c, par_q;
  logic signed [NW-1:0] s_num_q, s_den_q, t_num_q, t_den_q;

  assign par_c = det_q < $signed(NW'(limit_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_q <= par_c;
      if (par_c) begin
        s_num_q <= '0;
        s_den_q <= NW'(1);
        if (duv6 > dvv6) begin
          t_num_q <= NW'(duw6);
          t_den_q <= NW'(duv6);
        end else begin
          t_num_q <= NW'(dvw6);
          t_den_q <= NW'(dvv6);
        end
      end else begin
        s_num_q <= ns_q;
        s_den_q <= det_q;
        t_num_q <= nt_q;
        t_den_q <= det_q;
      end
    end
  end

  logic signed [DataW-1:0] s_par, t_par;
  logic                    s_deg, t_deg;

  llcp_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_s (
    .clk_i, .en_i(en), .num_i(s_num_q), .den_i(s_den_q), .quo_o(s_par), .deg_o(s_deg));
  llcp_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_t (
    .clk_i, .en_i(en), .num_i(t_num_q), .den_i(t_den_q), .quo_o(t_par), .deg_o(t_deg));

  // Directions and gap travel alongside the quotient pipeline.
  logic [SideW-1:0]        side_d, side_q;
  logic signed [DataW-1:0] dir1_r [3], dir2_r [3];
  logic signed [GW-1:0]    gap_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_d[k*DataW +: DataW]               = dir1_q[k];
      side_d[(3+k)*DataW +: DataW]           = dir2_q[k];
      side_d[6*DataW + k*GW +: GW]           = gap_q[k];
      dir1_r[k] = $signed(side_q[k*DataW +: DataW]);
      dir2_r[k] = $signed(side_q[(3+k)*DataW +: DataW]);
      gap_r[k]  = $signed(side_q[6*DataW + k*GW +: GW]);
    end
  end

  llcp_dly #(.W(SideW), .N(LatDiv - LatS1)) u_dly_side (
    .clk_i, .rst_ni, .en_i(en), .d_i(side_d), .q_o(side_q));

  // Distance stage 1: parameter times direction.
  logic signed [2*DataW-1:0] su_q [3], tv_q [3];
  logic signed [GW-1:0]      gapd_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        su_q[k]   <= (2*DataW)'(s_par) * (2*DataW)'(dir1_r[k]);
        tv_q[k]   <= (2*DataW)'(t_par) * (2*DataW)'(dir2_r[k]);
        gapd_q[k] <= gap_r[k];
      end
    end
  end

  // Distance stage 2: components of the closest-point difference.
  logic signed [CW-1:0] comp_c [3];
  logic signed [QW-1:0] cq_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp_c[k] = (CW'(gapd_q[k]) <<< FRAC_BITS) + CW'(su_q[k]) - CW'(tv_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) cq_q[k] <= QW'(comp_c[k] >>> FRAC_BITS);
    end
  end

  logic signed [SQW-1:0] sq [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    llcp_smul #(.AW(QW), .BW(QW)) u_mul_sq (
      .clk_i, .en_i(en), .a_i(cq_q[k]), .b_i(cq_q[k]), .p_o(sq[k]));
  end

  // Sum of squares and range check for the root.
  logic [SSW-1:0]  sumsq_c;
  logic [RadW-1:0] rad_q;
  logic            sat_q;

  assign sumsq_c = $unsigned(SSW'(sq[0]) + SSW'(sq[1]) + SSW'(sq[2]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= sumsq_c[RadW-1:0];
      sat_q <= |sumsq_c[SSW-1:RadW];
    end
  end

  logic [RootBits-1:0] root;

  llcp_sqrt u_sqrt (.clk_i, .en_i(en), .val_i(rad_q), .root_o(root));

  logic [2*DataW:0] st_q;
  logic             par_end, sat_end;

  llcp_dly #(.W(2 * DataW + 1), .N(LatEnd - LatDiv)) u_dly_st (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({s_deg | t_deg, s_par, t_par}), .q_o(st_q));
  llcp_dly #(.W(1), .N(LatEnd - LatSel)) u_dly_par (
    .clk_i, .rst_ni, .en_i(en), .d_i(par_q), .q_o(par_end));
  llcp_dly #(.W(1), .N(LatEnd - LatSum)) u_dly_sat (
    .clk_i, .rst_ni, .en_i(en), .d_i(sat_q), .q_o(sat_end));
  llcp_dly #(.W(1), .N(LatEnd)) u_dly_valid (
    .clk_i, .rst_ni, .en_i(en), .d_i(in_valid_i), .q_o(v_end));

  // Output register.
  logic                    out_valid_d, out_valid_q;
  logic [DataW-1:0]        dist_q;
  logic signed [DataW-1:0] s_out_q, t_out_q;
  logic                    par_out_q, deg_out_q;

  assign en          = !(out_valid_q && out_stall_i && v_end);
  assign in_stall_o  = !en;
  assign out_valid_d = en ? (v_end || (out_valid_q && out_stall_i)) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_end) begin
      dist_q    <= sat_end ? '1 : DataW'(root);
      s_out_q   <= $signed(st_q[2*DataW-1:DataW]);
      t_out_q   <= $signed(st_q[DataW-1:0]);
      par_out_q <= par_end;
      deg_out_q <= st_q[2*DataW] | sat_end;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign closest_distance_o = dist_q;
  assign first_param_o      = s_out_q;
  assign second_param_o     = t_out_q;
  assign parallel_flag_o    = par_out_q;
  assign degenerate_flag_o  = deg_out_q;

endmodule

[rtl/core/llcp_checker.sv]
// Port-level checks for the line-line closest points unit, with the bind that attaches them.
// Sees only the top-level ports; depends on llcp_pkg.
module llcp_checker
  import llcp_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [DataW-1:0]        closest_distance_o,
  input logic signed [DataW-1:0] first_param_o,
  input logic                    parallel_flag_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(closest_distance_o) && $stable(first_param_o))
    else $error("Output payload changed while stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a waiting output transaction.");

  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parallel_flag_o |-> first_param_o == '0)
    else $error("Parallel result with nonzero first parameter.");

endmodule

bind line_line_closest_points_unit llcp_checker u_llcp_checker (.*);
